// ===== design/edsa_pkg.sv =====
// Shared types and fixed field widths for the encoder detent step accumulator.
// Used by the serial divider and the top level; depends on nothing else.
package edsa_pkg;

    // Widths fixed by the external fields.
    localparam int FIELD_W  = 32;
    localparam int DETENT_W = 16;

    // Top-level sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_MAG  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } edsa_state_t;

    // Request from the sequencer to the serial divider.
    typedef struct packed {
        logic                start;
        logic [DETENT_W-1:0] divisor;
    } edsa_div_ctrl_t;

    // Status returned by the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
        logic q_nonzero;
    } edsa_div_stat_t;

endpackage

// ===== design/edsa_serdiv.sv =====
// Bit-serial restoring divider: unsigned magnitude by a 16-bit divisor.
// One quotient bit per cycle; depends on edsa_pkg for widths and the control structs.
module edsa_serdiv #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  edsa_pkg::edsa_div_ctrl_t       ctrl,
    input  logic [VALUE_WIDTH-1:0]         dividend,
    output edsa_pkg::edsa_div_stat_t       stat,
    output logic [VALUE_WIDTH-1:0]         quotient,
    output logic [edsa_pkg::DETENT_W-1:0]  remainder
);
    import edsa_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [DETENT_W-1:0]    rem_reg;
    logic [DETENT_W-1:0]    dvs_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   qnz_reg;

    logic [DETENT_W:0]      trial;
    logic                   qbit;
    logic [DETENT_W:0]      diff;
    logic [DETENT_W-1:0]    rem_next;
    logic [VALUE_WIDTH-1:0] quo_next;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff     = trial - {1'b0, dvs_reg};
        qbit     = (trial >= {1'b0, dvs_reg});
        rem_next = qbit ? diff[DETENT_W-1:0] : trial[DETENT_W-1:0];
        quo_next = {quo_reg[VALUE_WIDTH-2:0], qbit};
    end

    // Control: bit counter, busy and a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            qnz_reg  <= 1'b0;
        end
        else if (ctrl.start)
        begin
            cnt_reg  <= CW'(VALUE_WIDTH);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            qnz_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            qnz_reg <= qnz_reg | qbit;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: the quotient shifts in where the dividend shifts out.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= ctrl.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.q_nonzero = qnz_reg;
    assign quotient       = quo_reg;
    assign remainder      = rem_reg;

endmodule

// ===== design/encoder_detent_step_accumulator.sv =====
// Top level of the encoder detent step accumulator: sequencer, state and output register.
// Depends on edsa_pkg and instantiates the bit-serial divider edsa_serdiv.
//
//  channel   signals                          width  direction
//  sample    sample_valid/sample_stall/position  32  in  (block drives stall)
//  step      step_valid/step_stall/steps         32  out (sink drives stall)
//  config    cfg_valid/cfg_ready/detent_size     16  in
//
// A primed sample passes through ACC, MAG, DIV and FIN, and the block takes
// no new sample until it is back in IDLE; in DIV the serial divider produces one
// quotient bit per cycle. The very first sample after reset only records the
// position. Reset leaves the divisor at 1 and the residue at zero. A stalled
// result waits in the output register while the next sample is taken; the
// sequencer holds only if a second result is ready before the first has gone.
module encoder_detent_step_accumulator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [edsa_pkg::FIELD_W-1:0]  position,
    output logic                                 step_valid,
    input  logic                                 step_stall,
    output logic signed [edsa_pkg::FIELD_W-1:0]  steps,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [edsa_pkg::DETENT_W-1:0]        detent_size
);
    import edsa_pkg::*;

    localparam int QW = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;

    edsa_state_t state_reg, state_next;

    logic                   primed_reg;
    logic [DETENT_W-1:0]    detent_reg;
    logic [VALUE_WIDTH-1:0] pos_reg;
    logic [VALUE_WIDTH-1:0] prev_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] residue_reg;
    logic                   neg_reg;
    logic                   step_valid_reg;
    logic [FIELD_W-1:0]     step_reg;

    logic                   sample_beat;
    logic                   out_free;
    logic signed [63:0]     pos64;
    logic [VALUE_WIDTH-1:0] pos_ext;
    logic [VALUE_WIDTH-1:0] mag;
    logic [QW-1:0]          q_wide;
    logic [FIELD_W-1:0]     q32;
    logic [VALUE_WIDTH-1:0] r_wide;

    edsa_div_ctrl_t         div_ctrl;
    edsa_div_stat_t         div_stat;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DETENT_W-1:0]    remainder;

    // Handshakes and operand shaping.
    always_comb
    begin
        sample_stall = (state_reg != S_IDLE);
        cfg_ready    = (state_reg == S_IDLE);
        sample_beat  = sample_valid && !sample_stall;
        out_free     = !step_valid_reg || !step_stall;
        pos64        = 64'(position);
        pos_ext      = pos64[VALUE_WIDTH-1:0];
        mag          = acc_reg[VALUE_WIDTH-1] ? (~acc_reg + 1'b1) : acc_reg;
        q_wide       = QW'(quotient);
        q32          = q_wide[FIELD_W-1:0];
        r_wide       = VALUE_WIDTH'(remainder);
        div_ctrl.start   = (state_reg == S_MAG);
        div_ctrl.divisor = (detent_reg == '0) ? DETENT_W'(1) : detent_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (sample_beat && primed_reg) state_next = S_ACC;
            S_ACC:  state_next = S_MAG;
            S_MAG:  state_next = S_DIV;
            S_DIV:  if (div_stat.done) state_next = S_FIN;
            S_FIN:  if (!div_stat.q_nonzero || out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: sequencer, primed flag, divisor register, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            primed_reg     <= 1'b0;
            detent_reg     <= DETENT_W'(1);
            step_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sample_beat)
                primed_reg <= 1'b1;
            if (cfg_valid && cfg_ready)
                detent_reg <= detent_size;
            if (state_reg == S_FIN && div_stat.q_nonzero && out_free)
                step_valid_reg <= 1'b1;
            else if (step_valid_reg && !step_stall)
                step_valid_reg <= 1'b0;
        end
    end

    // Position history and the residue accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            residue_reg <= '0;
        end
        else
        begin
            if (sample_beat && !primed_reg)
                prev_reg <= pos_ext;
            else if (state_reg == S_ACC)
                prev_reg <= pos_reg;
            if (state_reg == S_FIN)
            begin
                if (!div_stat.q_nonzero)
                    residue_reg <= acc_reg;
                else if (out_free)
                    residue_reg <= neg_reg ? (~r_wide + 1'b1) : r_wide;
            end
        end
    end

    // Working registers and the output payload.
    always_ff @(posedge clk)
    begin
        if (sample_beat)
            pos_reg <= pos_ext;
        if (state_reg == S_ACC)
            acc_reg <= residue_reg + (pos_reg - prev_reg);
        if (state_reg == S_MAG)
            neg_reg <= acc_reg[VALUE_WIDTH-1];
        if (state_reg == S_FIN && div_stat.q_nonzero && out_free)
            step_reg <= neg_reg ? (~q32 + 1'b1) : q32;
    end

    edsa_serdiv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (mag),
        .stat      (div_stat),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign step_valid = step_valid_reg;
    assign steps      = step_reg;

    // While the sequencer waits on the divider, the divider must be running or finishing.
    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("sequencer waits on an idle divider");

    // A new result only ever comes from the finishing state.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(step_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finishing state");

    // The first sample after reset only primes the block.
    a_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_beat && !primed_reg) |=> (state_reg == S_IDLE && primed_reg))
        else $error("first sample did not just prime the block");

endmodule
